// ===== src/deq_pkg.sv =====
package deq_pkg;

  localparam int VALUE_W = 32;

  // operation codes
  localparam logic [2:0] OP_DISPLAY    = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK   = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // value returned by a pop on an empty queue
  localparam logic signed [VALUE_W-1:0] EMPTY_POP_VALUE = -32'sd1;

  typedef logic [4:0] occ_t;

  typedef struct packed {
    logic [2:0]                 operation;
    logic signed [VALUE_W-1:0]  value_in;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value_out;
    logic [1:0]                 status;
    occ_t                       occupancy;
    logic                       last;
  } out_word_t;

  // result descriptor from the controller; value is replaced by the
  // ring read data when use_mem is set
  typedef struct packed {
    logic                       valid;
    logic                       use_mem;
    logic signed [VALUE_W-1:0]  value;
    logic [1:0]                 status;
    occ_t                       occupancy;
    logic                       last;
  } res_t;

endpackage

// ===== src/deq_ring_mem.sv =====
module deq_ring_mem #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IW-1:0]               waddr,
  input  logic [deq_pkg::VALUE_W-1:0] wdata,
  input  logic                        re,
  input  logic [IW-1:0]               raddr,
  output logic [deq_pkg::VALUE_W-1:0] rdata
);

  logic [deq_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [deq_pkg::VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/deq_ctrl.sv =====
module deq_ctrl #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  deq_pkg::in_word_t           in_data,
  output logic                        busy,
  output logic                        mem_we,
  output logic [IW-1:0]               mem_waddr,
  output logic [deq_pkg::VALUE_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [IW-1:0]               mem_raddr,
  output deq_pkg::res_t               res_nxt
);

  localparam int SW = CW + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SHOW = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          accept;
  logic          empty;
  logic          full;
  logic          show_last;

  // ring position base + off, with base < DEPTH and off <= DEPTH
  function automatic logic [IW-1:0] ring_pos(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign busy      = (state_r == ST_SHOW);
  assign accept    = start && !busy;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  assign show_last = (idx_r == count_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    mem_we    = 1'b0;
    mem_waddr = front_r;
    mem_wdata = in_data.value_in;
    mem_re    = 1'b0;
    mem_raddr = front_r;
    res_nxt   = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            deq_pkg::OP_DISPLAY: begin
              res_nxt.valid     = 1'b1;
              res_nxt.occupancy = deq_pkg::occ_t'(count_r);
              if (empty) begin
                res_nxt.status = deq_pkg::STATUS_EMPTY;
                res_nxt.last   = 1'b1;
              end else begin
                mem_re            = 1'b1;
                mem_raddr         = front_r;
                res_nxt.use_mem   = 1'b1;
                res_nxt.status    = deq_pkg::STATUS_OK;
                res_nxt.last      = (count_r == CW'(1));
                if (count_r != CW'(1)) begin
                  state_nxt = ST_SHOW;
                  idx_nxt   = CW'(1);
                end
              end
            end
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
              res_nxt.valid = 1'b1;
              res_nxt.value = in_data.value_in;
              res_nxt.last  = 1'b1;
              if (full) begin
                res_nxt.status    = deq_pkg::STATUS_FULL;
                res_nxt.occupancy = deq_pkg::occ_t'(count_r);
              end else begin
                mem_we            = 1'b1;
                count_nxt         = count_r + CW'(1);
                res_nxt.status    = deq_pkg::STATUS_OK;
                res_nxt.occupancy = deq_pkg::occ_t'(count_nxt);
                if (in_data.operation == deq_pkg::OP_PUSH_FRONT) begin
                  front_nxt = (front_r == '0) ? IW'(DEPTH - 1) : front_r - IW'(1);
                  mem_waddr = front_nxt;
                end else begin
                  mem_waddr = ring_pos(front_r, count_r);
                end
              end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
              res_nxt.valid = 1'b1;
              res_nxt.last  = 1'b1;
              if (empty) begin
                res_nxt.value     = deq_pkg::EMPTY_POP_VALUE;
                res_nxt.status    = deq_pkg::STATUS_EMPTY;
                res_nxt.occupancy = '0;
              end else begin
                mem_re            = 1'b1;
                count_nxt         = count_r - CW'(1);
                res_nxt.use_mem   = 1'b1;
                res_nxt.status    = deq_pkg::STATUS_OK;
                res_nxt.occupancy = deq_pkg::occ_t'(count_nxt);
                if (in_data.operation == deq_pkg::OP_POP_FRONT) begin
                  mem_raddr = front_r;
                  front_nxt = ring_pos(front_r, CW'(1));
                end else begin
                  mem_raddr = ring_pos(front_r, count_r - CW'(1));
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHOW: begin
        mem_re            = 1'b1;
        mem_raddr         = ring_pos(front_r, idx_r);
        res_nxt.valid     = 1'b1;
        res_nxt.use_mem   = 1'b1;
        res_nxt.status    = deq_pkg::STATUS_OK;
        res_nxt.occupancy = deq_pkg::occ_t'(count_r);
        res_nxt.last      = show_last;
        idx_nxt           = idx_r + CW'(1);
        if (show_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // a display walk only runs over a non-empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0))
    else $error("display walk with empty queue");

  // walk index stays inside the stored elements
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (idx_r < count_r) && (idx_r != '0))
    else $error("display index out of range");

  // a taken push grows the queue by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !full && (in_data.operation == deq_pkg::OP_PUSH_FRONT ||
                         in_data.operation == deq_pkg::OP_PUSH_BACK))
    |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the queue");

  // the element count never passes the ring depth
  assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> (count_r <= CW'(DEPTH)) && !$past(busy))
    else $error("count changed out of place");

endmodule

// ===== src/double_ended_queue_core.sv =====
// double-ended queue of signed 32-bit words kept in a ring memory
//
// input: a word (in_data: operation, value_in) is taken on a rising edge
// with start high and busy low. operations: display, push front, push back,
// pop front, pop back; other codes are dropped without a result.
// output: each result word sits on out_data for one cycle with out_valid
// high; the receiver cannot stall, so every word must be taken as shown.
// latency: a result appears the cycle after its word is taken.
// throughput: push and pop use one ring memory access apiece, so they
// can run back to back. display reads one stored element per cycle
// through the single read port, holding busy while it reads the elements
// after the front one; last flags the final word.
// full pushes are dropped with status full, empty pops give -1 and
// status empty, an empty display gives one word with status empty.
// reset (rst_n low, synchronous) empties the queue and clears the output
// strobe; ring contents are not cleared, only written entries are read.
// occupancy reports the count in 5 bits.
module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  deq_pkg::in_word_t    in_data,
  output logic                 out_valid,
  output deq_pkg::out_word_t   out_data
);

  localparam int IW = $clog2(DEPTH);

  logic                               mem_we;
  logic [IW-1:0]                      mem_waddr;
  logic [deq_pkg::VALUE_W-1:0]        mem_wdata;
  logic                               mem_re;
  logic [IW-1:0]                      mem_raddr;
  logic [deq_pkg::VALUE_W-1:0]        mem_rdata;
  deq_pkg::res_t                      res_nxt;
  deq_pkg::res_t                      res_r;

  // pointers, count and the display walk
  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res_nxt   (res_nxt)
  );

  // ring storage, read data registered and valid the cycle after the read
  deq_ring_mem #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result descriptor lines up with the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  // popped and displayed words come straight from the ring read register
  assign out_valid          = res_r.valid;
  assign out_data.value_out = res_r.use_mem ? signed'(mem_rdata) : res_r.value;
  assign out_data.status    = res_r.status;
  assign out_data.occupancy = res_r.occupancy;
  assign out_data.last      = res_r.last;

  // display words arrive in an unbroken run until last
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("display run broken");

  // a word taken with a known operation yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.operation == deq_pkg::OP_DISPLAY ||
                        in_data.operation == deq_pkg::OP_PUSH_FRONT ||
                        in_data.operation == deq_pkg::OP_PUSH_BACK ||
                        in_data.operation == deq_pkg::OP_POP_FRONT ||
                        in_data.operation == deq_pkg::OP_POP_BACK))
    |=> out_valid)
    else $error("missing result");

endmodule

// ===== test/tb_double_ended_queue_core.sv =====
`timescale 1ns / 100ps

module tb_double_ended_queue_core;

  localparam int DEPTH        = 16;
  localparam int RANDOM_WORDS = 300;
  localparam int LIMIT_CYCLES = 200000;

  // operation codes the block drops without a result
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  localparam logic signed [deq_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [deq_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // a word waiting to go out, optionally held until every result is back
  typedef struct {
    deq_pkg::in_word_t word;
    bit                drain_first;
  } planned_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  deq_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  deq_pkg::out_word_t out_data;

  planned_word_t      planned_words[$];
  deq_pkg::out_word_t expected_words[$];

  // queue contents as the block should hold them
  logic signed [deq_pkg::VALUE_W-1:0] ring_copy [DEPTH];
  int                                 head_pos = 0;
  int                                 stored_cnt = 0;

  // stimulus planning state: only the element count is tracked
  int  plan_count = 0;
  int  planned_items = 0;
  bit  drain_next = 1'b0;

  // sender burst / gap pacing
  int  burst_left = 1;
  int  gap_left = 0;

  int  mismatches = 0;
  int  cycle_cnt = 0;
  deq_pkg::out_word_t oldest;
  planned_word_t      next_word;

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected result words for one accepted input word
  function automatic void predict_deque(deq_pkg::in_word_t w);
    deq_pkg::out_word_t r;
    int k;
    r = '0;
    r.last = 1'b1;
    case (w.operation)
      deq_pkg::OP_DISPLAY: begin
        if (stored_cnt == 0) begin
          r.status = deq_pkg::STATUS_EMPTY;
          expected_words.push_back(r);
        end else begin
          // one word per element, front to back
          for (k = 0; k < stored_cnt; k++) begin
            r.value_out = ring_copy[(head_pos + k) % DEPTH];
            r.status    = deq_pkg::STATUS_OK;
            r.occupancy = deq_pkg::occ_t'(stored_cnt);
            r.last      = (k + 1 == stored_cnt);
            expected_words.push_back(r);
          end
        end
      end
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        r.value_out = w.value_in;
        if (stored_cnt >= DEPTH) begin
          // full: value dropped but echoed back
          r.status = deq_pkg::STATUS_FULL;
        end else begin
          if (w.operation == deq_pkg::OP_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            ring_copy[head_pos] = w.value_in;
          end else begin
            ring_copy[(head_pos + stored_cnt) % DEPTH] = w.value_in;
          end
          stored_cnt++;
          r.status = deq_pkg::STATUS_OK;
        end
        r.occupancy = deq_pkg::occ_t'(stored_cnt);
        expected_words.push_back(r);
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (stored_cnt == 0) begin
          r.value_out = deq_pkg::EMPTY_POP_VALUE;
          r.status    = deq_pkg::STATUS_EMPTY;
        end else begin
          if (w.operation == deq_pkg::OP_POP_FRONT) begin
            r.value_out = ring_copy[head_pos];
            head_pos = (head_pos + 1) % DEPTH;
          end else begin
            r.value_out = ring_copy[(head_pos + stored_cnt - 1) % DEPTH];
          end
          stored_cnt--;
          r.status = deq_pkg::STATUS_OK;
        end
        r.occupancy = deq_pkg::occ_t'(stored_cnt);
        expected_words.push_back(r);
      end
      default: begin
        // unused codes: no result, no state change
      end
    endcase
  endfunction

  // bias values toward the extremes of the signed range
  function automatic logic signed [deq_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic plan_word(logic [2:0] op, logic signed [deq_pkg::VALUE_W-1:0] value);
    planned_word_t p;
    p.word.operation = op;
    p.word.value_in  = value;
    p.drain_first    = drain_next;
    drain_next = 1'b0;
    planned_words.push_back(p);
    case (op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: if (plan_count < DEPTH) plan_count++;
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:   if (plan_count > 0) plan_count--;
      default: ;
    endcase
    if (op <= deq_pkg::OP_POP_BACK) planned_items++;
  endtask

  // driver: one word at a time, held until start meets busy low
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_deque(in_data);
      if (start && busy) begin
        // word not taken yet, keep it on the port
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (planned_words.size() != 0 &&
                   (!planned_words[0].drain_first || expected_words.size() == 0)) begin
        next_word = planned_words.pop_front();
        start   <= 1'b1;
        in_data <= next_word.word;
        burst_left--;
        if (burst_left <= 0) begin
          // new burst; now and then a long stretch with no gaps
          burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // monitor: every strobed word is compared with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        oldest = expected_words.pop_front();
        check_field("value_out", oldest.value_out, out_data.value_out);
        check_field("status", 32'(oldest.status), 32'(out_data.status));
        check_field("occupancy", 32'(oldest.occupancy), 32'(out_data.occupancy));
        check_field("last", 32'(oldest.last), 32'(out_data.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int seg;
    int target;
    int k;
    int directed_items;

    // empty corner cases and dropped codes
    plan_word(deq_pkg::OP_DISPLAY, rand_value());
    plan_word(deq_pkg::OP_POP_FRONT, rand_value());
    plan_word(deq_pkg::OP_POP_BACK, rand_value());
    plan_word(OP_FIRST_UNUSED, rand_value());
    plan_word(OP_LAST_UNUSED, rand_value());
    // fill from both ends so the front index wraps, extremes first
    for (k = 0; k < DEPTH; k++) begin
      case (k)
        0:       plan_word(deq_pkg::OP_PUSH_FRONT, VALUE_MAX);
        1:       plan_word(deq_pkg::OP_PUSH_BACK, VALUE_MIN);
        2:       plan_word(deq_pkg::OP_PUSH_FRONT, -32'sd1);
        3:       plan_word(deq_pkg::OP_PUSH_BACK, '0);
        default: plan_word(k[0] ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT, $urandom);
      endcase
    end
    // pushes into a full queue, then a full-length display
    plan_word(deq_pkg::OP_PUSH_FRONT, rand_value());
    plan_word(deq_pkg::OP_PUSH_BACK, rand_value());
    plan_word(deq_pkg::OP_DISPLAY, rand_value());
    directed_items = planned_items;

    // random part: sender pauses until everything is back before it starts
    drain_next = 1'b1;
    while (planned_items < directed_items + RANDOM_WORDS) begin
      seg = $urandom_range(0, 9);
      if (seg <= 2) begin
        // fill toward a random level, sometimes past full
        target = $urandom_range(plan_count, DEPTH);
        while (plan_count < target)
          plan_word($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                    rand_value());
        if ($urandom_range(0, 1))
          repeat ($urandom_range(1, 3))
            plan_word($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                      rand_value());
      end else if (seg <= 4) begin
        // drain toward a random level, sometimes past empty
        target = $urandom_range(0, plan_count);
        while (plan_count > target)
          plan_word($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                    rand_value());
        if (plan_count == 0 && $urandom_range(0, 1))
          repeat ($urandom_range(1, 3))
            plan_word($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                      rand_value());
      end else if (seg == 5) begin
        plan_word(deq_pkg::OP_DISPLAY, rand_value());
      end else if (seg <= 8) begin
        // mixed traffic
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 8))
            0:       plan_word(deq_pkg::OP_DISPLAY, rand_value());
            1, 2:    plan_word(deq_pkg::OP_PUSH_FRONT, rand_value());
            3, 4:    plan_word(deq_pkg::OP_PUSH_BACK, rand_value());
            5, 6:    plan_word(deq_pkg::OP_POP_FRONT, rand_value());
            default: plan_word(deq_pkg::OP_POP_BACK, rand_value());
          endcase
        end
      end else begin
        // noise: codes the block ignores
        plan_word(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), rand_value());
      end
      if ($urandom_range(0, 15) == 0) drain_next = 1'b1;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // all words taken, all results in, then a short tail for strays
    while (planned_words.size() != 0 || start) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
